// File: design/qte_pkg.sv
// Shared types, constants and the arctangent table for the quaternion to
// Euler angle converter. Used by the top level, the CORDIC unit and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

    typedef struct packed {
        logic signed [15:0] quat_real;
        logic signed [15:0] quat_i;
        logic signed [15:0] quat_j;
        logic signed [15:0] quat_k;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic               invalid_input;
    } t_euler;

    // Width of the atan2 arguments as they enter a CORDIC unit.
    localparam int ARG_W        = 34;
    // Working width of the CORDIC vector and of the Q30 angle.
    localparam int CORDIC_W     = 45;
    localparam int ANGLE_W      = 35;
    // Arguments are prescaled so the larger magnitude lands in [2^40, 2^41).
    localparam int PRESCALE_BIT = 40;

    localparam logic signed [ANGLE_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    // 180 * 128 / pi in Q16.
    localparam logic signed [29:0]        DEG_K_Q16   = 30'sd480631834;

    // Side information that travels with each item through the pipeline.
    typedef struct packed {
        logic vld;
        logic inv;
        logic sat_pos;
        logic sat_neg;
    } t_side;

    // atan(2^-idx) in Q30 radians.
    function automatic logic [29:0] f_atan_q30(input int unsigned idx);
        logic [29:0] res;
        case (idx)
            0:       res = 30'd843314857;
            1:       res = 30'd497837829;
            2:       res = 30'd263043837;
            3:       res = 30'd133525159;
            4:       res = 30'd67021687;
            5:       res = 30'd33543516;
            6:       res = 30'd16775851;
            7:       res = 30'd8388437;
            8:       res = 30'd4194283;
            9:       res = 30'd2097149;
            10:      res = 30'd1048576;
            11:      res = 30'd524288;
            12:      res = 30'd262144;
            13:      res = 30'd131072;
            14:      res = 30'd65536;
            15:      res = 30'd32768;
            16:      res = 30'd16384;
            17:      res = 30'd8192;
            18:      res = 30'd4096;
            19:      res = 30'd2048;
            20:      res = 30'd1024;
            21:      res = 30'd512;
            22:      res = 30'd256;
            23:      res = 30'd128;
            default: res = 30'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/qte_cordic.sv
// Pipelined vectoring-mode CORDIC that gives atan2(y, x) in Q30 radians.
// Depends on qte_pkg for widths, pi and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module qte_cordic
    import qte_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [ARG_W-1:0]   i_y,
    input  logic signed [ARG_W-1:0]   i_x,
    output logic signed [ANGLE_W-1:0] o_z
);

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic        [CORDIC_W-1:0] m;
        logic signed [ANGLE_W-1:0]  z;
        logic                       zero;
    } t_cv;

    // Shift the vector left by s when the magnitude stays below 2^41.
    function automatic t_cv f_norm(input t_cv a, input int unsigned s);
        t_cv res;
        res = a;
        if ((a.m >> (PRESCALE_BIT + 1 - s)) == '0) begin
            res.m = a.m << s;
            res.x = a.x <<< s;
            res.y = a.y <<< s;
        end
        return res;
    endfunction

    t_cv r_pre [0:3];
    t_cv n_pre [0:3];
    t_cv r_it  [0:STAGES-1];
    t_cv n_it  [0:STAGES-1];

    // Fold the left half plane onto the right one and find the magnitude.
    always_comb begin
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic        [CORDIC_W-1:0] ax;
        logic        [CORDIC_W-1:0] ay;
        xs = CORDIC_W'(i_x);
        ys = CORDIC_W'(i_y);
        n_pre[0].zero = (i_x == '0) && (i_y == '0);
        if (xs < 0) begin
            n_pre[0].z = (ys >= 0) ? PI_Q30 : -PI_Q30;
            n_pre[0].x = -xs;
            n_pre[0].y = -ys;
        end else begin
            n_pre[0].z = '0;
            n_pre[0].x = xs;
            n_pre[0].y = ys;
        end
        ax = n_pre[0].x[CORDIC_W-1] ? CORDIC_W'(-n_pre[0].x) : CORDIC_W'(n_pre[0].x);
        ay = n_pre[0].y[CORDIC_W-1] ? CORDIC_W'(-n_pre[0].y) : CORDIC_W'(n_pre[0].y);
        n_pre[0].m = (ax > ay) ? ax : ay;
        // Prescale in three stages of two binary steps each.
        n_pre[1] = f_norm(f_norm(r_pre[0], 32), 16);
        n_pre[2] = f_norm(f_norm(r_pre[1], 8), 4);
        n_pre[3] = f_norm(f_norm(r_pre[2], 2), 1);
    end

    // One micro-rotation per stage.
    always_comb begin
        t_cv                        src;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [ANGLE_W-1:0]  step_ang;
        for (int k = 0; k < STAGES; k++) begin
            src      = (k == 0) ? r_pre[3] : r_it[k-1];
            dx       = src.y >>> k;
            dy       = src.x >>> k;
            step_ang = ANGLE_W'(f_atan_q30(k));
            n_it[k]  = src;
            if (src.y > 0) begin
                n_it[k].x = src.x + dx;
                n_it[k].y = src.y - dy;
                n_it[k].z = src.z + step_ang;
            end else begin
                n_it[k].x = src.x - dx;
                n_it[k].y = src.y + dy;
                n_it[k].z = src.z - step_ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < 4; s++) begin
                r_pre[s] <= n_pre[s];
            end
            for (int k = 0; k < STAGES; k++) begin
                r_it[k] <= n_it[k];
            end
        end
    end

    assign o_z = r_it[STAGES-1].zero ? '0 : r_it[STAGES-1].z;

endmodule

`default_nettype wire

// File: design/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angle (Z-Y-X) converter.
// Depends on qte_pkg and on qte_cordic, of which it holds three instances.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_in_data  (t_quat)
//   output    out        o_out_valid / i_out_stall  o_out_data (t_euler)
//   config    in         i_cfg_wr_en                i_cfg_wr_data (angle_in_degrees)
//
// One quaternion can be accepted in every cycle in which o_in_stall is low.
// Each result passes the products, the sums, the pitch front end with the 32
// steps of its square root, the pitch CORDIC unit and two output registers.
// Reset clears every valid bit and sets the mode to degrees.
// While the output register holds a result that is stalled, the whole pipeline
// freezes and o_in_stall is raised; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_quat  i_in_data,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_euler o_out_data,
    input  logic   i_cfg_wr_en,
    input  logic   i_cfg_wr_data
);

    // Latency of one CORDIC unit: fold, three prescale stages, micro-rotations.
    localparam int CLAT       = 4 + CORDIC_STAGES;
    // The integer square root resolves one result bit per stage.
    localparam int SQRT_STEPS = 32;
    // Pitch front end after the sums: saturation check and three normalize
    // stages, the two squares, the difference, then the square root steps.
    localparam int PRE        = 5 + SQRT_STEPS;
    localparam int SIDE_LEN   = PRE + CLAT;

    typedef struct packed {
        logic        [30:0] den;
        logic signed [31:0] num;
    } t_pnorm;

    // Shift the asin ratio left by s while the denominator stays below 2^31.
    function automatic t_pnorm f_pnorm_step(input t_pnorm a, input int unsigned s);
        t_pnorm res;
        res = a;
        if ((a.den >> (31 - s)) == '0) begin
            res.den = a.den << s;
            res.num = a.num <<< s;
        end
        return res;
    endfunction

    // Round the Q30 angle into output units and saturate to 16 bits.
    function automatic logic signed [15:0] f_units(input logic signed [ANGLE_W-1:0] z,
                                                   input logic signed [63:0] prod,
                                                   input logic deg);
        logic signed [63:0] v;
        if (deg) begin
            v = (prod + (64'sd1 <<< 45)) >>> 46;
        end else begin
            v = (64'(z) + 64'sd65536) >>> 17;
        end
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Pipeline advance: everything moves unless a finished result is stalled.
    logic w_en;

    logic r_mode;

    // Stage 1: products of the components.
    logic               r_s1_vld;
    logic signed [31:0] r_rr, r_ii, r_jj, r_kk;
    logic signed [31:0] r_ij, r_kr, r_jr, r_ik, r_jk, r_ir;

    // Stage 2: atan2 arguments, asin numerator and squared norm.
    logic                   r_s2_vld;
    logic signed [ARG_W-1:0] r_yaw_y, r_yaw_x, r_roll_y, r_roll_x, r_pnum;
    logic        [32:0]     r_den;

    // Pitch front end.
    t_pnorm             n_pn1, n_pn2, n_pn3;
    t_pnorm             r_pn1, r_pn2, r_pn3;
    logic               n_sat_pos, n_sat_neg;
    logic        [61:0] r_pm_den2, r_pm_an2;
    logic signed [31:0] r_pm_num;
    logic        [63:0] r_sq_v   [0:SQRT_STEPS];
    logic        [63:0] r_sq_r   [0:SQRT_STEPS];
    logic signed [31:0] r_sq_num [0:SQRT_STEPS];
    logic        [63:0] n_sq_v   [1:SQRT_STEPS];
    logic        [63:0] n_sq_r   [1:SQRT_STEPS];

    t_side r_side [0:SIDE_LEN-1];

    // CORDIC results and the delay lines that line up yaw and roll with pitch.
    logic signed [ANGLE_W-1:0] yaw_z, roll_z, pitch_z;
    logic signed [ARG_W-1:0]   pitch_y, pitch_x;
    logic signed [ANGLE_W-1:0] r_yaw_dly  [0:PRE-1];
    logic signed [ANGLE_W-1:0] r_roll_dly [0:PRE-1];
    logic signed [ANGLE_W-1:0] pitch_sel;

    // Stage after the CORDIC units: angles and their degree products.
    logic                      r_u1_vld;
    logic                      r_u1_inv;
    logic signed [ANGLE_W-1:0] r_u1_yaw, r_u1_pitch, r_u1_roll;
    logic signed [63:0]        r_u1_yaw_p, r_u1_pitch_p, r_u1_roll_p;

    logic   r_out_vld;
    t_euler r_out;

    assign w_en        = !r_out_vld || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Mode register. The user must write it only while no transfer is in flight; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Valid bits and side information.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_u1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < SIDE_LEN; k++) begin
                r_side[k] <= '0;
            end
        end else if (w_en) begin
            r_s1_vld          <= i_in_valid;
            r_s2_vld          <= r_s1_vld;
            r_side[0].vld     <= r_s2_vld;
            r_side[0].inv     <= (r_den == '0);
            r_side[0].sat_pos <= n_sat_pos;
            r_side[0].sat_neg <= n_sat_neg;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_u1_vld  <= r_side[SIDE_LEN-1].vld;
            r_out_vld <= r_u1_vld;
        end
    end

    // Component products and the sums built from them.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rr <= i_in_data.quat_real * i_in_data.quat_real;
            r_ii <= i_in_data.quat_i * i_in_data.quat_i;
            r_jj <= i_in_data.quat_j * i_in_data.quat_j;
            r_kk <= i_in_data.quat_k * i_in_data.quat_k;
            r_ij <= i_in_data.quat_i * i_in_data.quat_j;
            r_kr <= i_in_data.quat_k * i_in_data.quat_real;
            r_jr <= i_in_data.quat_j * i_in_data.quat_real;
            r_ik <= i_in_data.quat_i * i_in_data.quat_k;
            r_jk <= i_in_data.quat_j * i_in_data.quat_k;
            r_ir <= i_in_data.quat_i * i_in_data.quat_real;

            r_yaw_y  <= (ARG_W'(r_ij) + ARG_W'(r_kr)) <<< 1;
            r_yaw_x  <= ARG_W'(r_ii) - ARG_W'(r_jj) - ARG_W'(r_kk) + ARG_W'(r_rr);
            r_roll_y <= (ARG_W'(r_jk) + ARG_W'(r_ir)) <<< 1;
            r_roll_x <= ARG_W'(r_kk) + ARG_W'(r_rr) - ARG_W'(r_ii) - ARG_W'(r_jj);
            r_pnum   <= (ARG_W'(r_jr) - ARG_W'(r_ik)) <<< 1;
            r_den    <= 33'($unsigned(r_ii)) + 33'($unsigned(r_jj))
                      + 33'($unsigned(r_kk)) + 33'($unsigned(r_rr));
        end
    end

    // Pitch: saturation test, then bring the norm into [2^30, 2^31) so that
    // its square fits a 62-bit word.
    always_comb begin
        logic signed [34:0] num_e;
        logic signed [34:0] den_e;
        logic signed [34:0] num_r;
        logic        [32:0] den_r;
        t_pnorm             pre;
        num_e     = 35'(r_pnum);
        den_e     = 35'($signed({1'b0, r_den}));
        n_sat_pos = (num_e >= den_e);
        n_sat_neg = (-num_e >= den_e);
        if (r_den[32]) begin
            den_r = r_den >> 2;
            num_r = num_e >>> 2;
        end else if (r_den[31]) begin
            den_r = r_den >> 1;
            num_r = num_e >>> 1;
        end else begin
            den_r = r_den;
            num_r = num_e;
        end
        pre.den = den_r[30:0];
        pre.num = num_r[31:0];
        n_pn1   = f_pnorm_step(pre, 16);
        n_pn2   = f_pnorm_step(f_pnorm_step(r_pn1, 8), 4);
        n_pn3   = f_pnorm_step(f_pnorm_step(r_pn2, 2), 1);
    end

    // Integer square root of den^2 - num^2, one result bit per stage.
    always_comb begin
        logic [63:0] b;
        logic [63:0] sum;
        for (int t = 0; t < SQRT_STEPS; t++) begin
            b   = 64'd1 << (62 - 2 * t);
            sum = r_sq_r[t] + b;
            if (r_sq_v[t] >= sum) begin
                n_sq_v[t+1] = r_sq_v[t] - sum;
                n_sq_r[t+1] = (r_sq_r[t] >> 1) + b;
            end else begin
                n_sq_v[t+1] = r_sq_v[t];
                n_sq_r[t+1] = r_sq_r[t] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [30:0] an;
        if (w_en) begin
            r_pn1 <= n_pn1;
            r_pn2 <= n_pn2;
            r_pn3 <= n_pn3;

            an        = r_pn3.num[31] ? 31'(-r_pn3.num) : r_pn3.num[30:0];
            r_pm_den2 <= 62'(r_pn3.den) * 62'(r_pn3.den);
            r_pm_an2  <= 62'(an) * 62'(an);
            r_pm_num  <= r_pn3.num;

            r_sq_v[0]   <= 64'(r_pm_den2 - r_pm_an2);
            r_sq_r[0]   <= '0;
            r_sq_num[0] <= r_pm_num;
            for (int t = 1; t <= SQRT_STEPS; t++) begin
                r_sq_v[t]   <= n_sq_v[t];
                r_sq_r[t]   <= n_sq_r[t];
                r_sq_num[t] <= r_sq_num[t-1];
            end
        end
    end

    assign pitch_y = ARG_W'(r_sq_num[SQRT_STEPS]);
    assign pitch_x = $signed({3'b000, r_sq_r[SQRT_STEPS][30:0]});

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_yaw_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_yaw_y),
        .i_x   (r_yaw_x),
        .o_z   (yaw_z)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_roll_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_roll_y),
        .i_x   (r_roll_x),
        .o_z   (roll_z)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_pitch_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (pitch_y),
        .i_x   (pitch_x),
        .o_z   (pitch_z)
    );

    // Yaw and roll finish ahead of pitch; hold them back in delay lines.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yaw_dly[0]  <= yaw_z;
            r_roll_dly[0] <= roll_z;
            for (int k = 1; k < PRE; k++) begin
                r_yaw_dly[k]  <= r_yaw_dly[k-1];
                r_roll_dly[k] <= r_roll_dly[k-1];
            end
        end
    end

    // A ratio at or beyond one gives exactly plus or minus a right angle.
    always_comb begin
        if (r_side[SIDE_LEN-1].sat_pos) begin
            pitch_sel = HALF_PI_Q30;
        end else if (r_side[SIDE_LEN-1].sat_neg) begin
            pitch_sel = -HALF_PI_Q30;
        end else begin
            pitch_sel = pitch_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u1_inv     <= r_side[SIDE_LEN-1].inv;
            r_u1_yaw     <= r_yaw_dly[PRE-1];
            r_u1_pitch   <= pitch_sel;
            r_u1_roll    <= r_roll_dly[PRE-1];
            r_u1_yaw_p   <= 64'(r_yaw_dly[PRE-1]) * 64'(DEG_K_Q16);
            r_u1_pitch_p <= 64'(pitch_sel) * 64'(DEG_K_Q16);
            r_u1_roll_p  <= 64'(r_roll_dly[PRE-1]) * 64'(DEG_K_Q16);

            // A zero norm forces all angles to zero and flags the result.
            r_out.invalid_input <= r_u1_inv;
            r_out.yaw_angle     <= r_u1_inv ? '0 : f_units(r_u1_yaw, r_u1_yaw_p, r_mode);
            r_out.pitch_angle   <= r_u1_inv ? '0 : f_units(r_u1_pitch, r_u1_pitch_p, r_mode);
            r_out.roll_angle    <= r_u1_inv ? '0 : f_units(r_u1_roll, r_u1_roll_p, r_mode);
        end
    end

endmodule

`default_nettype wire

// File: design/qte_checker.sv
// Port-level checks for the quaternion to Euler angle converter, attached by bind.
// Depends on qte_pkg and on the top level quaternion_to_euler_angles.
`timescale 1ns / 1ps
`default_nettype none

module qte_checker
    import qte_pkg::*;
(
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   i_in_valid,
    input wire logic   o_in_stall,
    input wire t_quat  i_in_data,
    input wire logic   o_out_valid,
    input wire logic   i_out_stall,
    input wire t_euler o_out_data,
    input wire logic   i_cfg_wr_en,
    input wire logic   i_cfg_wr_data
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // The input side is held back only by a stalled result.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // Reset leaves no result on the port.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A zero norm gives zero angles.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.invalid_input |->
            o_out_data.yaw_angle == 16'sd0 && o_out_data.pitch_angle == 16'sd0
            && o_out_data.roll_angle == 16'sd0)
        else $error("invalid result with nonzero angle");

    // Pitch never leaves a right angle in either unit.
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.pitch_angle <= 16'sd12900 && o_out_data.pitch_angle >= -16'sd12900)
        else $error("pitch beyond a right angle");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);

`default_nettype wire
